// ===== design/qvt_pkg.sv =====
package qvt_pkg;

    // field and register widths
    localparam int OP_W      = 2;
    localparam int ST_W      = 8;
    localparam int AI_W      = 3;
    localparam int VAL_W     = 32;
    localparam int RND_W     = 16;
    localparam int CFG_W     = 9;
    localparam int ACT_W     = 4;
    localparam int CFG_IDX_W = 1;

    // largest column count the actions register can express
    localparam int ACT_MAXV = (1 << ACT_W) - 1;

    // remainder unit retires two dividend bits per step
    localparam int MOD_STEPS = RND_W / 2;

    localparam int DEF_MAX_STATES  = 256;
    localparam int DEF_MAX_ACTIONS = 8;

    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_MAX    = 2'd2;
    localparam logic [OP_W-1:0] OP_SELECT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_STATES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIONS = 1'b1;

    localparam logic [CFG_W-1:0] STATES_RST  = 9'd256;
    localparam logic [ACT_W-1:0] ACTIONS_RST = 4'd4;

    typedef struct packed {
        logic clr;        // clear sweep: zero one entry
        logic load;       // capture input item
        logic mem_wr;     // store write value
        logic rd_one;     // read addressed entry
        logic cap_rd;     // latch read data
        logic scan;       // row scan: issue reads, fold returns
        logic mod_step;   // two bits of random mod ties
        logic pick_step;  // walk tie mask one column
        logic out_load;   // fill output register
    } t_cmd;

    typedef struct packed {
        logic            clr_last;
        logic            err;
        logic [OP_W-1:0] op;
        logic            scan_done;
        logic            mod_last;
        logic            pick_hit;
        logic            out_free;
    } t_sts;

endpackage

// ===== design/qvt_ctrl.sv =====
module qvt_ctrl
    import qvt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_CAPT  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_MOD   = 3'd5;
    localparam logic [2:0] S_PICK  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.err) begin
                    n_state = S_DONE;
                end else begin
                    case (i_sts.op)
                        OP_WRITE: begin
                            o_cmd.mem_wr = 1'b1;
                            n_state      = S_DONE;
                        end
                        OP_READ: begin
                            o_cmd.rd_one = 1'b1;
                            n_state      = S_CAPT;
                        end
                        default: begin
                            n_state = S_SCAN;
                        end
                    endcase
                end
            end
            S_CAPT: begin
                o_cmd.cap_rd = 1'b1;
                n_state      = S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = (i_sts.op == OP_MAX) ? S_DONE : S_MOD;
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_last) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                o_cmd.pick_step = 1'b1;
                if (i_sts.pick_hit) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.out_load = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== design/qvt_dp.sv =====
module qvt_dp
    import qvt_pkg::*;
#(
    parameter int MAX_STATES  = DEF_MAX_STATES,
    parameter int MAX_ACTIONS = DEF_MAX_ACTIONS
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic [OP_W-1:0]         i_opcode,
    input  logic [ST_W-1:0]         i_state_index,
    input  logic [AI_W-1:0]         i_action_index,
    input  logic signed [VAL_W-1:0] i_write_value,
    input  logic [RND_W-1:0]        i_random_value,
    input  t_cmd                    i_cmd,
    output t_sts                    o_sts,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [VAL_W-1:0] o_result_value,
    output logic [AI_W-1:0]         o_chosen_action,
    output logic                    o_index_error
);

    localparam int DEPTH = MAX_STATES * MAX_ACTIONS;
    localparam int AW    = $clog2(DEPTH);
    localparam int MW    = (MAX_ACTIONS < ACT_MAXV) ? MAX_ACTIONS : ACT_MAXV;
    localparam int MIW   = $clog2(MW);
    localparam int MCW   = $clog2(MOD_STEPS);

    // config
    logic [CFG_W-1:0] r_states;
    logic [ACT_W-1:0] r_actions;
    logic [CFG_W-1:0] eff_states;
    logic [ACT_W-1:0] eff_actions;

    // item
    logic [OP_W-1:0]  r_op;
    logic [ST_W-1:0]  r_s;
    logic [AI_W-1:0]  r_a;
    logic [VAL_W-1:0] r_wv;
    logic             r_err;
    logic             in_err;
    logic             row_ok;
    logic             col_ok;

    // table
    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;
    logic [AW-1:0]    r_clr_addr;
    logic [AW-1:0]    entry_addr;
    logic [AW-1:0]    waddr;
    logic [VAL_W-1:0] wdata;
    logic [ACT_W-1:0] col_sel;
    logic             we;
    logic             rd_en;

    // scan
    logic [ACT_W-1:0]        r_col;
    logic [ACT_W-1:0]        r_rd_col;
    logic                    r_rd_vld;
    logic                    issue;
    logic                    fold;
    logic                    scan_done;
    logic signed [VAL_W-1:0] r_best;
    logic signed [VAL_W-1:0] rd_val;
    logic [ACT_W-1:0]        r_ties;
    logic [MW-1:0]           r_mask;
    logic [MW-1:0]           fold_bit;

    // remainder and pick
    logic [RND_W-1:0] r_rsh;
    logic [ACT_W-1:0] r_rem;
    logic [MCW-1:0]   r_mcnt;
    logic [ACT_W:0]   t1;
    logic [ACT_W:0]   t2;
    logic [ACT_W-1:0] rem2;
    logic [ACT_W-1:0] r_seen;
    logic [AI_W-1:0]  r_chosen;
    logic [MIW-1:0]   pick_idx;
    logic             pick_hit;

    // output register
    logic                    r_out_vld;
    logic signed [VAL_W-1:0] r_res_val;
    logic [AI_W-1:0]         r_res_act;
    logic                    r_res_err;
    logic                    out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_states  <= STATES_RST;
            r_actions <= ACTIONS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STATES:  r_states  <= i_cfg_data;
                CFG_ACTIONS: r_actions <= i_cfg_data[ACT_W-1:0];
                default: ;
            endcase
        end
    end

    // oversized settings clamp to the table size
    assign eff_states  = (32'(r_states) > 32'(MAX_STATES)) ? CFG_W'(MAX_STATES) : r_states;
    assign eff_actions = (32'(r_actions) > 32'(MAX_ACTIONS)) ? ACT_W'(MAX_ACTIONS) : r_actions;

    assign row_ok = ({1'b0, i_state_index} < eff_states) && (eff_actions != '0);
    assign col_ok = ({1'b0, i_action_index} < eff_actions);
    assign in_err = !row_ok || (((i_opcode == OP_WRITE) || (i_opcode == OP_READ)) && !col_ok);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_opcode;
            r_s   <= i_state_index;
            r_a   <= i_action_index;
            r_wv  <= i_write_value;
            r_err <= in_err;
        end
    end

    assign col_sel    = (i_cmd.rd_one || i_cmd.mem_wr) ? {1'b0, r_a} : r_col;
    assign entry_addr = AW'(r_s) * AW'(MAX_ACTIONS) + AW'(col_sel);
    assign issue      = i_cmd.scan && (r_col < eff_actions);
    assign rd_en      = i_cmd.rd_one || issue;
    assign we         = i_cmd.clr || i_cmd.mem_wr;
    assign waddr      = i_cmd.clr ? r_clr_addr : entry_addr;
    assign wdata      = i_cmd.clr ? '0 : r_wv;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rdata <= mem[entry_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= (r_clr_addr == AW'(DEPTH - 1)) ? '0 : r_clr_addr + 1'b1;
        end
    end

    // scan: registered read, fold one column per cycle
    assign rd_val    = signed'(r_rdata);
    assign fold      = i_cmd.scan && r_rd_vld;
    assign scan_done = r_rd_vld && (r_rd_col == eff_actions - 1'b1);

    always_comb begin
        fold_bit = '0;
        fold_bit[r_rd_col[MIW-1:0]] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_col <= r_col;
        if (fold) begin
            if ((r_rd_col == '0) || (rd_val > r_best)) begin
                r_best <= rd_val;
                r_ties <= ACT_W'(1);
                r_mask <= fold_bit;
            end else if (rd_val == r_best) begin
                r_ties <= r_ties + 1'b1;
                r_mask <= r_mask | fold_bit;
            end
        end else if (i_cmd.cap_rd) begin
            r_best <= rd_val;
        end
    end

    // random mod ties, restoring, two bits per step
    always_comb begin
        t1 = {r_rem, r_rsh[RND_W-1]};
        if (t1 >= {1'b0, r_ties}) begin
            t1 = t1 - {1'b0, r_ties};
        end
        t2 = {t1[ACT_W-1:0], r_rsh[RND_W-2]};
        if (t2 >= {1'b0, r_ties}) begin
            t2 = t2 - {1'b0, r_ties};
        end
        rem2 = t2[ACT_W-1:0];
    end

    assign pick_idx = r_col[MIW-1:0];
    assign pick_hit = r_mask[pick_idx] && (r_seen == r_rem);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rsh  <= i_random_value;
            r_rem  <= '0;
            r_mcnt <= '0;
            r_col  <= '0;
        end else if (issue) begin
            r_col <= r_col + 1'b1;
        end else if (fold && scan_done) begin
            r_col  <= '0;
            r_seen <= '0;
        end else if (i_cmd.mod_step) begin
            r_rem  <= rem2;
            r_rsh  <= {r_rsh[RND_W-3:0], 2'b00};
            r_mcnt <= r_mcnt + 1'b1;
        end else if (i_cmd.pick_step) begin
            if (pick_hit) begin
                r_chosen <= r_col[AI_W-1:0];
            end else begin
                r_col <= r_col + 1'b1;
                if (r_mask[pick_idx]) begin
                    r_seen <= r_seen + 1'b1;
                end
            end
        end
    end

    assign out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_res_val <= (!r_err && ((r_op == OP_READ) || (r_op == OP_MAX))) ? r_best : '0;
            r_res_act <= (!r_err && (r_op == OP_SELECT)) ? r_chosen : '0;
            r_res_err <= r_err;
        end
    end

    assign o_sts.clr_last  = (r_clr_addr == AW'(DEPTH - 1));
    assign o_sts.err       = r_err;
    assign o_sts.op        = r_op;
    assign o_sts.scan_done = scan_done;
    assign o_sts.mod_last  = (r_mcnt == MCW'(MOD_STEPS - 1));
    assign o_sts.pick_hit  = pick_hit;
    assign o_sts.out_free  = out_free;

    assign o_out_valid     = r_out_vld;
    assign o_result_value  = r_res_val;
    assign o_chosen_action = r_res_act;
    assign o_index_error   = r_res_err;

`ifndef SYNTH
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("output register overwritten");

    a_ties_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fold |=> (r_ties != '0))
        else $error("tie count zero after fold");

    a_rem_below_ties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pick_step |-> (r_rem < r_ties))
        else $error("remainder not below tie count");

    a_pick_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pick_step |-> (r_col < eff_actions))
        else $error("pick walked past active columns");
`endif

endmodule

// ===== design/q_value_table_argmax.sv =====
// Channel  | Signals                                  | Dir | Transfer when
// ---------+------------------------------------------+-----+-----------------------
// in       | i_in_valid/o_in_ready, i_opcode,         | in  | i_in_valid & o_in_ready
//          | i_state_index, i_action_index,           |     |
//          | i_write_value, i_random_value            |     |
// out      | o_out_valid/i_out_ready, o_result_value, | out | o_out_valid & i_out_ready
//          | o_chosen_action, o_index_error           |     |
// cfg      | i_cfg_we, i_cfg_index, i_cfg_data        | in  | i_cfg_we
//
// Items are handled one at a time. Row max and select scan the row with one table
//   read per column through the single read port; select then runs 8 steps of the
//   2-bit remainder unit for random mod ties and walks the tie mask one column per
//   cycle.
// Reset clears the table by a sweep over all MAX_STATES*MAX_ACTIONS entries (2048 by default);
//   no item is taken during the sweep, config writes are.
// A finished result sits in the output register; the next item is taken while it
//   waits, and that item stalls at its end until the register drains.
module q_value_table_argmax
    import qvt_pkg::*;
#(
    parameter int MAX_STATES  = DEF_MAX_STATES,
    parameter int MAX_ACTIONS = DEF_MAX_ACTIONS
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data,
    // input items
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [OP_W-1:0]         i_opcode,
    input  logic [ST_W-1:0]         i_state_index,
    input  logic [AI_W-1:0]         i_action_index,
    input  logic signed [VAL_W-1:0] i_write_value,
    input  logic [RND_W-1:0]        i_random_value,
    // results
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [VAL_W-1:0] o_result_value,
    output logic [AI_W-1:0]         o_chosen_action,
    output logic                    o_index_error
);

    t_cmd cmd;   // controller -> datapath
    t_sts sts;   // datapath -> controller

    // Sequencer: clear sweep, idle, dispatch, then the per-opcode phases
    // (read capture, row scan, remainder, tie walk) and output load.
    qvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Table memory, config registers, range checks, max/tie tracking,
    // remainder unit, tie walk and output register.
    qvt_dp #(
        .MAX_STATES  (MAX_STATES),
        .MAX_ACTIONS (MAX_ACTIONS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (i_opcode),
        .i_state_index   (i_state_index),
        .i_action_index  (i_action_index),
        .i_write_value   (i_write_value),
        .i_random_value  (i_random_value),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_result_value  (o_result_value),
        .o_chosen_action (o_chosen_action),
        .o_index_error   (o_index_error)
    );

endmodule
